// File: hw/rtl/binary_min_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// Binary min-heap queue assertion macros
// Concurrent assertion wrappers shared by the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

`define BMHQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define BMHQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BMHQ_ASSERT(label, prop, msg)

`define BMHQ_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: hw/rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Shared constants, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_PUT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/bmhq_cmp.sv
// ----------------------------------------------------------------------------
// Heap key comparator
// Shared signed key compare: flags a < b and returns the smaller key.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_cmp (
    input  wire logic signed [bmhq_pkg::KEY_W-1:0] i_a,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0] i_b,
    output logic                                   o_less,
    output logic signed [bmhq_pkg::KEY_W-1:0]      o_min
);

    always_comb begin
        o_less = (i_a < i_b);
        o_min  = o_less ? i_a : i_b;
    end

endmodule

`default_nettype wire

// File: hw/rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Array-based min-heap of signed keys with insert and extract-minimum words.
//
//   channel   direction   handshake             ports
//   command   in          start & !busy         i_command, i_key_in
//   result    out         o_valid, one cycle    o_key_out, o_status, o_count
//
// Insert: the key rises one level per compare step and is then written to its
// slot. Extract: S_EX_ROOT and S_EX_LAST fetch the root and the last key, then
// each level reads the left and then the right child (both children share one
// read port); S_PUT places the key at a leaf. Full and empty errors leave busy low.
// The result word shows in the first idle cycle, when the next command may be taken.
// Reset clears state, count and valid only, not the heap; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_command,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]   i_key_in,
    output logic                                     o_valid,
    output logic signed [bmhq_pkg::KEY_W-1:0]        o_key_out,
    output logic [bmhq_pkg::STATUS_W-1:0]            o_status,
    output logic [CW-1:0]                            o_count
);

    localparam int IW = AW + 2;

    bmhq_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_count, n_count;
    logic signed [bmhq_pkg::KEY_W-1:0] r_key, n_key;
    logic signed [bmhq_pkg::KEY_W-1:0] r_best, n_best;
    logic signed [bmhq_pkg::KEY_W-1:0] r_kout, n_kout;
    logic             r_lsel, n_lsel;

    logic             r_valid, n_valid;
    logic signed [bmhq_pkg::KEY_W-1:0] r_okey, n_okey;
    bmhq_pkg::t_status r_ostat, n_ostat;
    logic [CW-1:0]    r_ocnt, n_ocnt;

    // Heap storage, one write and one registered read per cycle.
    logic signed [bmhq_pkg::KEY_W-1:0] r_heap [CAPACITY];
    logic signed [bmhq_pkg::KEY_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_wdata;

    logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b, cmp_min;
    logic             cmp_less;

    logic [AW-1:0]    cnt_pos;
    logic [AW-1:0]    up_parent;
    logic [IW-1:0]    lft, rgt, n_ext, child_lft;
    logic [AW-1:0]    child;
    logic signed [bmhq_pkg::KEY_W-1:0] child_val;
    logic             move;

    bmhq_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_less (cmp_less),
        .o_min  (cmp_min)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_heap[mem_raddr];
    end

    always_comb begin
        cnt_pos   = AW'(r_count);
        up_parent = AW'((r_pos - AW'(1)) >> 1);
        lft       = {1'b0, r_pos, 1'b1};
        rgt       = lft + IW'(1);
        n_ext     = IW'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_best  <= n_best;
        r_kout  <= n_kout;
        r_lsel  <= n_lsel;
        r_okey  <= n_okey;
        r_ostat <= n_ostat;
        r_ocnt  <= n_ocnt;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_key     = r_key;
        n_best    = r_best;
        n_kout    = r_kout;
        n_lsel    = r_lsel;
        n_valid   = 1'b0;
        n_okey    = r_okey;
        n_ostat   = r_ostat;
        n_ocnt    = r_ocnt;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_key;
        mem_raddr = '0;
        cmp_a     = r_key;
        cmp_b     = r_rdata;
        child     = r_pos;
        child_val = r_best;
        child_lft = {1'b0, r_pos, 1'b1};
        move      = 1'b0;

        unique case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (start) begin
                    if (i_command == bmhq_pkg::CMD_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_valid = 1'b1;
                            n_okey  = '0;
                            n_ostat = bmhq_pkg::ST_FULL;
                            n_ocnt  = r_count;
                        end else begin
                            n_key   = i_key_in;
                            n_kout  = '0;
                            n_pos   = cnt_pos;
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                n_state = bmhq_pkg::S_PUT;
                            end else begin
                                mem_raddr = AW'((cnt_pos - AW'(1)) >> 1);
                                n_state   = bmhq_pkg::S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_okey  = '0;
                            n_ostat = bmhq_pkg::ST_EMPTY;
                            n_ocnt  = r_count;
                        end else begin
                            n_count   = r_count - CW'(1);
                            mem_raddr = '0;
                            n_state   = bmhq_pkg::S_EX_ROOT;
                        end
                    end
                end
            end

            bmhq_pkg::S_UP_CMP: begin
                // The held key rises past a strictly greater parent.
                cmp_a = r_key;
                cmp_b = r_rdata;
                if (cmp_less) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_rdata;
                    n_pos     = up_parent;
                    if (up_parent == '0) begin
                        n_state = bmhq_pkg::S_PUT;
                    end else begin
                        mem_raddr = AW'((up_parent - AW'(1)) >> 1);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_key;
                    n_valid   = 1'b1;
                    n_okey    = r_kout;
                    n_ostat   = bmhq_pkg::ST_OK;
                    n_ocnt    = r_count;
                    n_state   = bmhq_pkg::S_IDLE;
                end
            end

            bmhq_pkg::S_EX_ROOT: begin
                // The count is already decremented, so it indexes the last key.
                n_kout    = r_rdata;
                mem_raddr = cnt_pos;
                n_state   = bmhq_pkg::S_EX_LAST;
            end

            bmhq_pkg::S_EX_LAST: begin
                n_key = r_rdata;
                n_pos = '0;
                if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_okey  = r_kout;
                    n_ostat = bmhq_pkg::ST_OK;
                    n_ocnt  = r_count;
                    n_state = bmhq_pkg::S_IDLE;
                end else if (r_count == CW'(1)) begin
                    n_state = bmhq_pkg::S_PUT;
                end else begin
                    mem_raddr = AW'(1);
                    n_state   = bmhq_pkg::S_DN_LEFT;
                end
            end

            bmhq_pkg::S_DN_LEFT: begin
                cmp_a     = r_rdata;
                cmp_b     = r_key;
                n_lsel    = cmp_less;
                n_best    = cmp_min;
                mem_raddr = AW'(rgt);
                n_state   = bmhq_pkg::S_DN_RIGHT;
            end

            bmhq_pkg::S_DN_RIGHT: begin
                // The right child wins only if strictly smaller than the best so far.
                cmp_a = r_rdata;
                cmp_b = r_best;
                if ((rgt < n_ext) && cmp_less) begin
                    move      = 1'b1;
                    child     = AW'(rgt);
                    child_val = r_rdata;
                end else if (r_lsel) begin
                    move      = 1'b1;
                    child     = AW'(lft);
                    child_val = r_best;
                end
                child_lft = {1'b0, child, 1'b1};
                if (move) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = child_val;
                    n_pos     = child;
                    if (child_lft < n_ext) begin
                        mem_raddr = AW'(child_lft);
                        n_state   = bmhq_pkg::S_DN_LEFT;
                    end else begin
                        n_state = bmhq_pkg::S_PUT;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_key;
                    n_valid   = 1'b1;
                    n_okey    = r_kout;
                    n_ostat   = bmhq_pkg::ST_OK;
                    n_ocnt    = r_count;
                    n_state   = bmhq_pkg::S_IDLE;
                end
            end

            bmhq_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_key;
                n_valid   = 1'b1;
                n_okey    = r_kout;
                n_ostat   = bmhq_pkg::ST_OK;
                n_ocnt    = r_count;
                n_state   = bmhq_pkg::S_IDLE;
            end

            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy      = (r_state != bmhq_pkg::S_IDLE);
    assign o_valid   = r_valid;
    assign o_key_out = r_okey;
    assign o_status  = r_ostat;
    assign o_count   = r_ocnt;

    `BMHQ_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "element count beyond capacity")
    `BMHQ_ASSERT(a_no_idle_write, (r_state == bmhq_pkg::S_IDLE) |-> !mem_we, "heap write while idle")
    `BMHQ_ASSERT(a_err_key_zero, (o_valid && o_status != bmhq_pkg::ST_OK) |-> (o_key_out == '0), "error word carries a key")
    `BMHQ_ASSERT(a_full_count, (o_valid && o_status == bmhq_pkg::ST_FULL) |-> (o_count == CW'(CAPACITY)), "full status below capacity")
    `BMHQ_ASSERT_NEXT(a_empty_report, !busy && start && i_command == bmhq_pkg::CMD_EXTRACT && r_count == '0, o_valid && o_status == bmhq_pkg::ST_EMPTY && o_count == '0, "empty extract not reported")

endmodule

`default_nettype wire
